// ===== hdl/tvn_pkg.sv =====
package tvn_pkg;

  localparam int unsigned FRAC_W = 16;
  localparam int unsigned VAL_W  = 7;
  localparam int unsigned WGT_W  = FRAC_W + 1;
  localparam int unsigned EX_W   = 23;
  localparam int unsigned EY_W   = 39;
  localparam int unsigned ACC_W  = 55;
  localparam int unsigned SPLIT  = 20;
  localparam int unsigned NOISE_W = 15;
  localparam int unsigned NOISE_LSB = 40;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

  localparam logic [ACC_W-1:0] SHADE_T1 = ACC_W'(20) << 48;
  localparam logic [ACC_W-1:0] SHADE_T2 = ACC_W'(40) << 48;
  localparam logic [ACC_W-1:0] SHADE_T3 = ACC_W'(60) << 48;
  localparam logic [ACC_W-1:0] SHADE_T4 = ACC_W'(80) << 48;

  localparam logic [2:0] SHADE_0 = 3'd0;
  localparam logic [2:0] SHADE_1 = 3'd1;
  localparam logic [2:0] SHADE_2 = 3'd2;
  localparam logic [2:0] SHADE_3 = 3'd3;
  localparam logic [2:0] SHADE_4 = 3'd4;

  typedef struct packed {
    logic              mode;
    logic [3:0]        cell_x;
    logic [3:0]        cell_y;
    logic [3:0]        cell_z;
    logic [VAL_W-1:0]  lattice_value;
    logic [FRAC_W-1:0] pos_x;
    logic [FRAC_W-1:0] pos_y;
    logic [FRAC_W-1:0] pos_z;
  } req_t;

  typedef struct packed {
    logic [NOISE_W-1:0] noise_value;
    logic [2:0]         shade_level;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic mode;
  } ctl_t;

  typedef struct packed {
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic [FRAC_W-1:0] fz;
  } frac_t;

  typedef logic [7:0][VAL_W-1:0] corner_t;

endpackage

// ===== hdl/tvn_split.sv =====
module tvn_split #(
  parameter int unsigned GRID_SIZE = 16,
  parameter int unsigned CW = $clog2(GRID_SIZE)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  tvn_pkg::req_t               req_i,
  output tvn_pkg::ctl_t               ctl_o,
  output logic [2:0][CW-1:0]          lo_o,
  output logic [2:0][CW-1:0]          hi_o,
  output logic [3*CW-1:0]             wr_addr_o,
  output logic [tvn_pkg::VAL_W-1:0]   wr_data_o,
  output tvn_pkg::frac_t              frac_o
);

  localparam int unsigned SW = tvn_pkg::FRAC_W + $clog2(GRID_SIZE + 1);
  localparam int unsigned XW = (CW > 4) ? CW : 4;
  localparam logic [CW:0] GRID_M = (CW + 1)'(GRID_SIZE);

  function automatic logic [3:0] wrap_cell(logic [3:0] c);
    logic [6:0] v;
    v = {3'b000, c};
    for (int i = 0; i < 8; i++) begin
      if (v >= 7'(GRID_SIZE)) begin
        v = v - 7'(GRID_SIZE);
      end
    end
    return v[3:0];
  endfunction

  logic [2:0][tvn_pkg::FRAC_W-1:0] pos;
  logic [2:0][SW-1:0]              scaled;
  logic [2:0][CW-1:0]              lo_d, hi_d;
  logic [2:0][CW:0]                nxt;
  logic [2:0][XW-1:0]              wcell;
  tvn_pkg::ctl_t                   ctl_q;
  logic [2:0][CW-1:0]              lo_q, hi_q;
  logic [3*CW-1:0]                 wr_addr_q;
  logic [tvn_pkg::VAL_W-1:0]       wr_data_q;
  tvn_pkg::frac_t                  frac_q;

  assign pos[0] = req_i.pos_x;
  assign pos[1] = req_i.pos_y;
  assign pos[2] = req_i.pos_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      scaled[a] = SW'(pos[a]) * SW'(GRID_SIZE);
      lo_d[a]   = scaled[a][tvn_pkg::FRAC_W +: CW];
      nxt[a]    = {1'b0, lo_d[a]} + (CW + 1)'(1);
      hi_d[a]   = (nxt[a] == GRID_M) ? '0 : nxt[a][CW-1:0];
    end
    wcell[0] = XW'(wrap_cell(req_i.cell_x));
    wcell[1] = XW'(wrap_cell(req_i.cell_y));
    wcell[2] = XW'(wrap_cell(req_i.cell_z));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q.valid <= valid_i;
      ctl_q.mode  <= req_i.mode;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      wr_addr_q <= {wcell[0][CW-1:0], wcell[1][CW-1:0], wcell[2][CW-1:0]};
      wr_data_q <= req_i.lattice_value;
      frac_q.fx <= scaled[0][tvn_pkg::FRAC_W-1:0];
      frac_q.fy <= scaled[1][tvn_pkg::FRAC_W-1:0];
      frac_q.fz <= scaled[2][tvn_pkg::FRAC_W-1:0];
    end
  end

  assign ctl_o     = ctl_q;
  assign lo_o      = lo_q;
  assign hi_o      = hi_q;
  assign wr_addr_o = wr_addr_q;
  assign wr_data_o = wr_data_q;
  assign frac_o    = frac_q;

endmodule

// ===== hdl/tvn_lattice.sv =====
module tvn_lattice #(
  parameter int unsigned GRID_SIZE = 16,
  parameter int unsigned CW = $clog2(GRID_SIZE)
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      wr_en_i,
  input  logic [3*CW-1:0]           wr_addr_i,
  input  logic [tvn_pkg::VAL_W-1:0] wr_data_i,
  input  logic [2:0][CW-1:0]        lo_i,
  input  logic [2:0][CW-1:0]        hi_i,
  output tvn_pkg::corner_t          rd_o
);

  localparam int unsigned AW    = 3 * CW;
  localparam int unsigned DEPTH = 1 << AW;

  logic [7:0][AW-1:0] addr;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      addr[k] = {(k[0] ? hi_i[0] : lo_i[0]),
                 (k[1] ? hi_i[1] : lo_i[1]),
                 (k[2] ? hi_i[2] : lo_i[2])};
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_copy
    logic [tvn_pkg::VAL_W-1:0] mem [DEPTH];
    logic [tvn_pkg::VAL_W-1:0] rd_a_q, rd_b_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (wr_en_i) begin
          mem[wr_addr_i] <= wr_data_i;
        end
        rd_a_q <= mem[addr[2*r]];
        rd_b_q <= mem[addr[2*r+1]];
      end
    end

    assign rd_o[2*r]   = rd_a_q;
    assign rd_o[2*r+1] = rd_b_q;
  end

endmodule

// ===== hdl/tvn_interp.sv =====
module tvn_interp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  tvn_pkg::corner_t          corner_i,
  input  tvn_pkg::frac_t            frac_i,
  output logic                      valid_o,
  output logic [tvn_pkg::ACC_W-1:0] acc_o
);

  localparam int unsigned XP_W = tvn_pkg::VAL_W + tvn_pkg::WGT_W + 1;
  localparam int unsigned YP_W = tvn_pkg::EX_W + tvn_pkg::WGT_W + 1;
  localparam int unsigned LO_W = tvn_pkg::SPLIT + tvn_pkg::WGT_W + 1;
  localparam int unsigned HI_W = tvn_pkg::EY_W - tvn_pkg::SPLIT + tvn_pkg::WGT_W + 1;

  logic [2:0] vld_q;
  logic       out_vld_q;

  logic [tvn_pkg::WGT_W-1:0] wx0, wx1, wy0, wy1, wz0, wz1;
  logic [3:0][XP_W-1:0]      ex_full;
  logic [1:0][YP_W-1:0]      ey_full;
  logic [LO_W-1:0]           pl_d;
  logic [HI_W-1:0]           ph_d;

  logic [3:0][tvn_pkg::EX_W-1:0] ex_q;
  logic [1:0][tvn_pkg::EY_W-1:0] ey_q;
  logic [LO_W-1:0]               pl_q;
  logic [HI_W-1:0]               ph_q;
  logic [tvn_pkg::FRAC_W-1:0]    fy_q, fz_c_q, fz_d_q;
  logic [tvn_pkg::ACC_W-1:0]     acc_q;

  assign wx1 = tvn_pkg::WGT_W'(frac_i.fx);
  assign wx0 = tvn_pkg::WGT_ONE - wx1;
  assign wy1 = tvn_pkg::WGT_W'(fy_q);
  assign wy0 = tvn_pkg::WGT_ONE - wy1;
  assign wz1 = tvn_pkg::WGT_W'(fz_d_q);
  assign wz0 = tvn_pkg::WGT_ONE - wz1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ex_full[i] = XP_W'(corner_i[2*i]) * XP_W'(wx0)
                 + XP_W'(corner_i[2*i+1]) * XP_W'(wx1);
    end
    for (int j = 0; j < 2; j++) begin
      ey_full[j] = YP_W'(ex_q[2*j]) * YP_W'(wy0) + YP_W'(ex_q[2*j+1]) * YP_W'(wy1);
    end
    pl_d = LO_W'(ey_q[0][tvn_pkg::SPLIT-1:0]) * LO_W'(wz0)
         + LO_W'(ey_q[1][tvn_pkg::SPLIT-1:0]) * LO_W'(wz1);
    ph_d = HI_W'(ey_q[0][tvn_pkg::EY_W-1:tvn_pkg::SPLIT]) * HI_W'(wz0)
         + HI_W'(ey_q[1][tvn_pkg::EY_W-1:tvn_pkg::SPLIT]) * HI_W'(wz1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[1:0], valid_i};
      out_vld_q <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        ex_q[i] <= ex_full[i][tvn_pkg::EX_W-1:0];
      end
      fy_q   <= frac_i.fy;
      fz_c_q <= frac_i.fz;
      for (int j = 0; j < 2; j++) begin
        ey_q[j] <= ey_full[j][tvn_pkg::EY_W-1:0];
      end
      fz_d_q <= fz_c_q;
      pl_q   <= pl_d;
      ph_q   <= ph_d;
      acc_q  <= (tvn_pkg::ACC_W'(ph_q) << tvn_pkg::SPLIT) + tvn_pkg::ACC_W'(pl_q);
    end
  end

  assign valid_o = out_vld_q;
  assign acc_o   = acc_q;

endmodule

// ===== hdl/trilinear_value_noise.sv =====
// Trilinear value noise over a wrapping cubic lattice of 7-bit values.
// Input channel: in_valid_i / in_stall_o carrying in_req_i. A request with
// mode write stores lattice_value at (cell_x, cell_y, cell_z), each index
// wrapped to the grid; it returns nothing. A request with mode sample gives
// three Q0.16 positions and returns one response.
// Output channel: out_valid_o / out_stall_i carrying out_rsp_o, with the
// noise value in Q7.8 (truncated) and a shade level of 0 to 4.
// The seven-stage pipeline (split, lattice read, x, y, z partial products, z
// sum, output register) takes one request per cycle while the receiver is
// not stalling with a response waiting.
// The eight corners come from four copies of the lattice, each read at two
// addresses per cycle; writes go to all copies.
// Requests are kept in order, so a write is seen by every later sample.
// When the receiver stalls with a response waiting, the whole pipeline
// holds and in_stall_o is raised; nothing is dropped or repeated.
// Reset clears all valid bits; the lattice holds no defined contents until
// written, and samples must only touch written entries.
module trilinear_value_noise #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tvn_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tvn_pkg::rsp_t out_rsp_o
);

  localparam int unsigned CW = $clog2(GRID_SIZE);

  logic                      adv;
  tvn_pkg::ctl_t             ctl_a;
  logic [2:0][CW-1:0]        lo_a, hi_a;
  logic [3*CW-1:0]           wr_addr_a;
  logic [tvn_pkg::VAL_W-1:0] wr_data_a;
  tvn_pkg::frac_t            frac_a;
  logic                      wr_en_a;
  tvn_pkg::corner_t          corner_b;
  logic                      smp_b_q;
  tvn_pkg::frac_t            frac_b_q;
  logic                      vld_f;
  logic [tvn_pkg::ACC_W-1:0] acc_f;
  logic                      out_vld_q;
  tvn_pkg::rsp_t             rsp_d, rsp_q;

  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;
  assign wr_en_a    = ctl_a.valid && (ctl_a.mode == tvn_pkg::MODE_WRITE);

  tvn_split #(
    .GRID_SIZE (GRID_SIZE),
    .CW        (CW)
  ) u_split (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (in_valid_i),
    .req_i     (in_req_i),
    .ctl_o     (ctl_a),
    .lo_o      (lo_a),
    .hi_o      (hi_a),
    .wr_addr_o (wr_addr_a),
    .wr_data_o (wr_data_a),
    .frac_o    (frac_a)
  );

  tvn_lattice #(
    .GRID_SIZE (GRID_SIZE),
    .CW        (CW)
  ) u_lattice (
    .clk_i     (clk_i),
    .en_i      (adv),
    .wr_en_i   (wr_en_a),
    .wr_addr_i (wr_addr_a),
    .wr_data_i (wr_data_a),
    .lo_i      (lo_a),
    .hi_i      (hi_a),
    .rd_o      (corner_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_b_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      smp_b_q   <= ctl_a.valid && (ctl_a.mode == tvn_pkg::MODE_SAMPLE);
      out_vld_q <= vld_f;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      frac_b_q <= frac_a;
      rsp_q    <= rsp_d;
    end
  end

  tvn_interp u_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (smp_b_q),
    .corner_i (corner_b),
    .frac_i   (frac_b_q),
    .valid_o  (vld_f),
    .acc_o    (acc_f)
  );

  always_comb begin
    rsp_d.noise_value = acc_f[tvn_pkg::NOISE_LSB +: tvn_pkg::NOISE_W];
    if (acc_f > tvn_pkg::SHADE_T4) begin
      rsp_d.shade_level = tvn_pkg::SHADE_4;
    end else if (acc_f > tvn_pkg::SHADE_T3) begin
      rsp_d.shade_level = tvn_pkg::SHADE_3;
    end else if (acc_f > tvn_pkg::SHADE_T2) begin
      rsp_d.shade_level = tvn_pkg::SHADE_2;
    end else if (acc_f > tvn_pkg::SHADE_T1) begin
      rsp_d.shade_level = tvn_pkg::SHADE_1;
    end else begin
      rsp_d.shade_level = tvn_pkg::SHADE_0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

  a_hold_stage_b : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(smp_b_q))
    else $error("sample valid moved while the pipeline was held");

  a_out_from_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_f))
    else $error("response raised without a finished sample");

  a_shade_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.shade_level <= tvn_pkg::SHADE_4))
    else $error("shade level out of range");

endmodule

// ===== verif/tb_trilinear_value_noise.sv =====
module tb_trilinear_value_noise;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REQ_W = $bits(tvn_pkg::req_t);

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  tvn_pkg::req_t  in_req_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  tvn_pkg::rsp_t  out_rsp_o;

  logic [tvn_pkg::VAL_W-1:0] lattice_mirror [4096];
  tvn_pkg::rsp_t             pending_noise [$];
  int unsigned               error_count = 0;
  int unsigned               sample_count = 0;
  int unsigned               write_count = 0;
  int unsigned               burst_left = 0;
  int unsigned               stall_phase = 0;
  int unsigned               stall_pct = 0;

  trilinear_value_noise u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned f);
    return a * (64'd65536 - f) + b * f;
  endfunction

  function automatic longint unsigned lat(logic [3:0] x, logic [3:0] y, logic [3:0] z);
    return 64'(lattice_mirror[{x, y, z}]);
  endfunction

  function automatic tvn_pkg::rsp_t predict_noise(tvn_pkg::req_t r);
    logic [3:0]       x0, x1, y0, y1, z0, z1;
    longint unsigned  fx, fy, fz, e00, e10, e01, e11, f0, f1, acc;
    tvn_pkg::rsp_t    p;
    x0 = r.pos_x[15:12];
    y0 = r.pos_y[15:12];
    z0 = r.pos_z[15:12];
    x1 = x0 + 4'd1;
    y1 = y0 + 4'd1;
    z1 = z0 + 4'd1;
    fx = 64'({r.pos_x[11:0], 4'b0});
    fy = 64'({r.pos_y[11:0], 4'b0});
    fz = 64'({r.pos_z[11:0], 4'b0});
    e00 = blend(lat(x0, y0, z0), lat(x1, y0, z0), fx);
    e10 = blend(lat(x0, y1, z0), lat(x1, y1, z0), fx);
    e01 = blend(lat(x0, y0, z1), lat(x1, y0, z1), fx);
    e11 = blend(lat(x0, y1, z1), lat(x1, y1, z1), fx);
    f0  = blend(e00, e10, fy);
    f1  = blend(e01, e11, fy);
    acc = blend(f0, f1, fz);
    p.noise_value = tvn_pkg::NOISE_W'(acc >> tvn_pkg::NOISE_LSB);
    if (acc > (64'd80 << 48)) p.shade_level = tvn_pkg::SHADE_4;
    else if (acc > (64'd60 << 48)) p.shade_level = tvn_pkg::SHADE_3;
    else if (acc > (64'd40 << 48)) p.shade_level = tvn_pkg::SHADE_2;
    else if (acc > (64'd20 << 48)) p.shade_level = tvn_pkg::SHADE_1;
    else p.shade_level = tvn_pkg::SHADE_0;
    return p;
  endfunction

  task automatic send_request(tvn_pkg::req_t r, bit bursty);
    bit          ok;
    int unsigned gap;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    forever begin
      @(negedge clk_i);
      ok = !in_stall_o;
      @(posedge clk_i);
      if (ok) break;
    end
    if (r.mode == tvn_pkg::MODE_WRITE) begin
      lattice_mirror[{r.cell_x, r.cell_y, r.cell_z}] = r.lattice_value;
      write_count++;
    end else begin
      pending_noise.push_back(predict_noise(r));
      sample_count++;
    end
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic tvn_pkg::req_t make_write(logic [3:0] x, logic [3:0] y, logic [3:0] z,
                                               logic [tvn_pkg::VAL_W-1:0] v);
    tvn_pkg::req_t r;
    r = tvn_pkg::req_t'(REQ_W'({$urandom, $urandom, $urandom}));
    r.mode = tvn_pkg::MODE_WRITE;
    r.cell_x = x;
    r.cell_y = y;
    r.cell_z = z;
    r.lattice_value = v;
    return r;
  endfunction

  function automatic tvn_pkg::req_t make_sample(logic [15:0] px, logic [15:0] py,
                                                logic [15:0] pz);
    tvn_pkg::req_t r;
    r = tvn_pkg::req_t'(REQ_W'({$urandom, $urandom, $urandom}));
    r.mode = tvn_pkg::MODE_SAMPLE;
    r.pos_x = px;
    r.pos_y = py;
    r.pos_z = pz;
    return r;
  endfunction

  // span 4 picks from 15, 0, 1, 2; span 3 from 15, 0, 1
  function automatic logic [3:0] rand_cell(int unsigned span);
    logic [3:0] c;
    c = 4'($urandom_range(0, span - 1));
    return (c == 4'd0) ? 4'd15 : c - 4'd1;
  endfunction

  function automatic logic [15:0] rand_pos();
    logic [3:0]  c;
    logic [11:0] f;
    c = rand_cell(3);
    case ($urandom_range(0, 5))
      0: f = 12'h000;
      1: f = 12'hFFF;
      default: f = 12'($urandom);
    endcase
    return {c, f};
  endfunction

  task automatic fill_lattice();
    logic [3:0] cells [4] = '{4'd15, 4'd0, 4'd1, 4'd2};
    foreach (cells[i])
      foreach (cells[j])
        foreach (cells[k])
          send_request(make_write(cells[i], cells[j], cells[k], 7'($urandom)), 1'b0);
  endtask

  task automatic test_shade_thresholds();
    logic [tvn_pkg::VAL_W-1:0] levels [8] =
      '{7'd0, 7'd20, 7'd21, 7'd40, 7'd41, 7'd80, 7'd81, 7'd127};
    foreach (levels[i]) begin
      send_request(make_write(4'd1, 4'd1, 4'd1, levels[i]), 1'b0);
      send_request(make_sample(16'h1000, 16'h1000, 16'h1000), 1'b0);
    end
  endtask

  task automatic test_wrap_edges();
    send_request(make_sample(16'h0000, 16'h0000, 16'h0000), 1'b0);
    send_request(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
    send_request(make_sample(16'hFFFF, 16'h0000, 16'h1800), 1'b0);
    send_request(make_sample(16'h0000, 16'hFFFF, 16'hF800), 1'b0);
    send_request(make_sample(16'hF001, 16'h1FFF, 16'hFFFF), 1'b0);
    send_request(make_write(4'd15, 4'd15, 4'd15, 7'd127), 1'b0);
    send_request(make_write(4'd0, 4'd0, 4'd0, 7'd127), 1'b0);
    send_request(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
    go_idle();
  endtask

  task automatic test_random_mix(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) begin
        go_idle();
        wait (pending_noise.size() == 0);
        @(posedge clk_i);
      end
      if ($urandom_range(0, 99) < 30)
        send_request(make_write(rand_cell(4), rand_cell(4), rand_cell(4), 7'($urandom)),
                     1'b1);
      else
        send_request(make_sample(rand_pos(), rand_pos(), rand_pos()), 1'b1);
    end
    go_idle();
  endtask

  always @(posedge clk_i) begin
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(4, 60);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 80;
        default: stall_pct = $urandom_range(10, 50);
      endcase
    end
    stall_phase--;
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(negedge clk_i) begin
    tvn_pkg::rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_noise.size() == 0) begin
        $display("%0t: response expected none actual %h", $realtime, out_rsp_o);
        error_count++;
      end else begin
        want = pending_noise.pop_front();
        if (out_rsp_o.noise_value !== want.noise_value) begin
          $display("%0t: noise_value expected %0d actual %0d",
                   $realtime, want.noise_value, out_rsp_o.noise_value);
          error_count++;
        end
        if (out_rsp_o.shade_level !== want.shade_level) begin
          $display("%0t: shade_level expected %0d actual %0d",
                   $realtime, want.shade_level, out_rsp_o.shade_level);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fill_lattice();
    test_shade_thresholds();
    test_wrap_edges();
    test_random_mix(1362);
    wait (pending_noise.size() == 0);
    repeat (20) @(posedge clk_i);
    if (pending_noise.size() != 0) begin
      $display("%0t: %0d responses still outstanding", $realtime, pending_noise.size());
      error_count++;
    end
    $display("Run covered %0d lattice writes and %0d noise samples,", write_count, sample_count);
    $display("including shade thresholds, wrap edges and a drain pause.");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tvn_pkg.sv
hdl/tvn_split.sv
hdl/tvn_lattice.sv
hdl/tvn_interp.sv
hdl/trilinear_value_noise.sv
verif/tb_trilinear_value_noise.sv
